>>> src/vtsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vtsm_pkg;

    // report codes
    localparam logic [1:0] KIND_DOWN    = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_ALL_UP  = 2'd2;

    localparam logic [7:0] ID_NONE     = 8'hFF;
    localparam logic [3:0] BASE_MAJOR  = 4'd9;
    localparam logic [4:0] SLOT_BASE   = 5'd10;
    localparam logic signed [3:0] JITTER_MAX = 4'sd5;
    localparam logic signed [3:0] JITTER_MIN = -4'sd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         slot;
        logic [3:0]         major;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               btn;
    } t_result;

endpackage

`default_nettype wire

>>> src/vtsm_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface vtsm_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         finger_id;
    logic               press;
    logic signed [14:0] pos_x;
    logic signed [14:0] pos_y;
    logic               exact_position;
    logic               real_finger_down;

    modport source (
        output valid, finger_id, press, pos_x, pos_y, exact_position, real_finger_down,
        input  ready
    );
    modport sink (
        input  valid, finger_id, press, pos_x, pos_y, exact_position, real_finger_down,
        output ready
    );
endinterface

interface vtsm_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         report_kind;
    logic [4:0]         slot_number;
    logic [3:0]         touch_major;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               button_down;
    logic               any_virtual_pressed;
    logic               last;

    modport source (
        output valid, report_kind, slot_number, touch_major, out_x, out_y,
               button_down, any_virtual_pressed, last,
        input  ready
    );
    modport sink (
        input  valid, report_kind, slot_number, touch_major, out_x, out_y,
               button_down, any_virtual_pressed, last,
        output ready
    );
endinterface

`default_nettype wire

>>> src/virtual_touch_slot_mapper.sv
// Virtual touch slot mapper: each input transfer carries one injected finger event and yields
// zero, one or two output transfers (a slot down or slot release report, then possibly an
// all-buttons-up report, the final one flagged by last). The slot table lives in a synchronous
// memory of NUM_SLOTS entries that is scanned one entry per cycle, highest index first. An event
// goes from acceptance to commit in order through a capture of the event, one read per slot, a
// step for the last read data and a commit that writes the table back and loads the result
// buffer. The next event is taken as soon as the commit is done, even while its results still
// wait in the buffer; a commit waits only while the buffer still holds results of the previous
// event. Per-entry valid bits clear the table at reset, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module virtual_touch_slot_mapper
    import vtsm_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    vtsm_in_if.sink     i_in,
    vtsm_out_if.source  o_out
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    // slot table: entry holds id plus one; a cleared valid bit reads as an empty slot
    logic [7:0]           mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_valid;

    t_state r_state, n_state;

    // captured event
    logic [7:0]         r_id;
    logic               r_press;
    logic signed [14:0] r_x;
    logic signed [14:0] r_y;
    logic               r_exact;
    logic               r_real_down;

    // scan pipeline
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_ridx;
    logic          r_rd_live;
    logic [7:0]    r_rdata;
    logic          r_rvbit;

    // scan results
    logic          r_has_match;
    logic [AW-1:0] r_match_idx;
    logic          r_has_empty;
    logic [AW-1:0] r_empty_idx;

    // persistent state
    logic [CW-1:0]      r_count;
    logic               r_pressed;
    logic signed [3:0]  r_jitter;

    // result buffer
    t_result    r_res0;
    t_result    r_res1;
    logic [1:0] r_out_cnt;
    logic       r_out_pos;
    logic       r_out_pressed;

    // fsm outputs
    logic in_ready;
    logic rd_en;
    logic commit;

    logic [7:0] tag;
    logic [7:0] entry;
    logic       slot_ok;

    // commit datapath
    logic          hit_press;
    logic          hit_release;
    logic [AW-1:0] sel_idx;
    logic [CW-1:0] n_count;
    logic          n_pressed;
    logic          all_empty;
    logic          has_up;
    t_result       slot_rep;
    t_result       up_rep;
    logic          out_xfer;
    t_result       cur;

    assign tag     = r_id + 8'd1;
    assign slot_ok = (r_id != ID_NONE);
    assign entry   = r_rvbit ? r_rdata : 8'd0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_addr == '0) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (r_out_cnt == 2'd0) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        commit   = 1'b0;
        unique case (r_state)
            S_IDLE:   in_ready = 1'b1;
            S_SCAN:   rd_en    = 1'b1;
            S_DRAIN:  ;
            S_COMMIT: commit   = (r_out_cnt == 2'd0);
            default:  ;
        endcase
    end

    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // event capture
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_id        <= i_in.finger_id;
            r_press     <= i_in.press;
            r_x         <= i_in.pos_x;
            r_y         <= i_in.pos_y;
            r_exact     <= i_in.exact_position;
            r_real_down <= i_in.real_finger_down;
        end
    end

    // read address walks from the top slot down to slot zero
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) r_addr <= AW'(NUM_SLOTS - 1);
        else if (rd_en)             r_addr <= AW'(r_addr - 1'b1);
    end

    // memory read port, registered
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[r_addr];
            r_rvbit <= r_valid[r_addr];
            r_ridx  <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rd_live <= 1'b0;
        else          r_rd_live <= rd_en;
    end

    // scan evaluation: a press keeps the lowest matching slot and the highest empty one,
    // a release keeps the highest matching slot
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_has_match <= 1'b0;
            r_has_empty <= 1'b0;
        end else if (r_rd_live) begin
            if (entry == tag && (r_press || !r_has_match)) begin
                r_has_match <= 1'b1;
                r_match_idx <= r_ridx;
            end
            if (entry == 8'd0 && !r_has_empty) begin
                r_has_empty <= 1'b1;
                r_empty_idx <= r_ridx;
            end
        end
    end

    // commit decisions
    always_comb begin
        hit_press   = slot_ok && r_press && (r_has_match || r_has_empty);
        hit_release = slot_ok && !r_press && r_has_match;
        sel_idx     = r_has_match ? r_match_idx : r_empty_idx;

        n_count = r_count;
        if (hit_press && !r_has_match) n_count = CW'(r_count + 1'b1);
        else if (hit_release)          n_count = CW'(r_count - 1'b1);

        all_empty = (n_count == '0);
        n_pressed = r_pressed;
        if (hit_press) n_pressed = 1'b1;
        if (all_empty) n_pressed = 1'b0;
        has_up = all_empty && !r_real_down;

        slot_rep       = '0;
        slot_rep.slot  = 5'(sel_idx) + SLOT_BASE;
        if (r_press) begin
            slot_rep.kind  = KIND_DOWN;
            slot_rep.major = 4'(BASE_MAJOR + r_jitter);
            slot_rep.x     = 16'(r_x) + (r_exact ? 16'sd0 : 16'(r_jitter));
            slot_rep.y     = 16'(r_y) + (r_exact ? 16'sd0 : 16'(r_jitter));
            slot_rep.btn   = !r_real_down;
        end else begin
            slot_rep.kind  = KIND_RELEASE;
        end

        up_rep      = '0;
        up_rep.kind = KIND_ALL_UP;
    end

    // table write-back
    always_ff @(posedge i_clk) begin
        if (commit && hit_press) mem[sel_idx] <= tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (commit) begin
            if (hit_press)   r_valid[sel_idx] <= 1'b1;
            if (hit_release) r_valid[sel_idx] <= 1'b0;
        end
    end

    // occupancy count, pressed flag and jitter offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_pressed <= 1'b0;
            r_jitter  <= JITTER_MIN;
        end else if (commit) begin
            r_count   <= n_count;
            r_pressed <= n_pressed;
            r_jitter  <= (r_jitter == JITTER_MAX) ? JITTER_MIN : 4'(r_jitter + 4'sd1);
        end
    end

    // result buffer
    assign out_xfer = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_res0        <= (hit_press || hit_release) ? slot_rep : up_rep;
            r_res1        <= up_rep;
            r_out_pressed <= n_pressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cnt <= 2'd0;
            r_out_pos <= 1'b0;
        end else if (commit) begin
            r_out_cnt <= 2'(hit_press || hit_release) + 2'(has_up);
            r_out_pos <= 1'b0;
        end else if (out_xfer) begin
            if (2'(r_out_pos) + 2'd1 == r_out_cnt) begin
                r_out_cnt <= 2'd0;
                r_out_pos <= 1'b0;
            end else begin
                r_out_pos <= 1'b1;
            end
        end
    end

    assign cur = r_out_pos ? r_res1 : r_res0;

    assign o_out.valid               = (r_out_cnt != 2'd0);
    assign o_out.report_kind         = cur.kind;
    assign o_out.slot_number         = cur.slot;
    assign o_out.touch_major         = cur.major;
    assign o_out.out_x               = cur.x;
    assign o_out.out_y               = cur.y;
    assign o_out.button_down         = cur.btn;
    assign o_out.any_virtual_pressed = r_out_pressed;
    assign o_out.last                = (2'(r_out_pos) + 2'd1 == r_out_cnt);

endmodule

`default_nettype wire

>>> tb/sv/vtsm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module vtsm_checker
    import vtsm_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    vtsm_in_if   i_evt,
    vtsm_out_if  i_rpt,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        t_result rpt;
        logic    pressed;
        logic    last;
    } t_report;

    // mirror of the slot table: id plus one, zero when empty
    logic [7:0]        slot_owner [NUM_SLOTS];
    logic signed [3:0] jitter;
    logic              pressed_flag;
    t_report           pending_reports [$];
    t_report           want;
    int                rpt_count;

    task automatic flag_error(input string msg);
        $display("[%0t] report %0d: %s", $time, rpt_count, msg);
        o_fail_count++;
    endtask

    // reports caused by one finger event, appended to the pending list
    function automatic void predict_reports(
        input logic [7:0]         id,
        input logic               press,
        input logic signed [14:0] px,
        input logic signed [14:0] py,
        input logic               exact,
        input logic               real_down
    );
        logic [7:0]         tag;
        int                 hit;
        logic               all_empty;
        logic signed [15:0] jit_wide;
        t_report            batch [$];
        t_report            r;

        tag       = id + 8'd1;
        hit       = -1;
        all_empty = 1'b1;
        jit_wide  = 16'(jitter);

        if (id != ID_NONE) begin
            if (press) begin
                // lowest slot holding the id wins, else highest empty slot
                for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
                    if (hit < 0 && slot_owner[i] == 8'd0)
                        hit = i;
                    if (slot_owner[i] == tag)
                        hit = i;
                end
                if (hit >= 0) begin
                    r           = '0;
                    r.rpt.kind  = KIND_DOWN;
                    r.rpt.slot  = 5'(hit) + SLOT_BASE;
                    r.rpt.major = BASE_MAJOR + jitter;
                    r.rpt.x     = 16'(px);
                    r.rpt.y     = 16'(py);
                    if (!exact) begin
                        r.rpt.x += jit_wide;
                        r.rpt.y += jit_wide;
                    end
                    r.rpt.btn = !real_down;
                    batch.push_back(r);
                    slot_owner[hit] = tag;
                    pressed_flag    = 1'b1;
                end
            end else begin
                for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
                    if (hit < 0 && slot_owner[i] == tag)
                        hit = i;
                end
                if (hit >= 0) begin
                    r          = '0;
                    r.rpt.kind = KIND_RELEASE;
                    r.rpt.slot = 5'(hit) + SLOT_BASE;
                    batch.push_back(r);
                    slot_owner[hit] = 8'd0;
                end
            end
        end

        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_owner[i] != 8'd0)
                all_empty = 1'b0;
        end
        if (all_empty) begin
            pressed_flag = 1'b0;
            if (!real_down) begin
                r          = '0;
                r.rpt.kind = KIND_ALL_UP;
                batch.push_back(r);
            end
        end

        if (jitter == JITTER_MAX)
            jitter = JITTER_MIN;
        else
            jitter = jitter + 4'sd1;

        foreach (batch[k]) begin
            batch[k].pressed = pressed_flag;
            batch[k].last    = (k == batch.size() - 1);
            pending_reports.push_back(batch[k]);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (slot_owner[i])
                slot_owner[i] = 8'd0;
            jitter       = JITTER_MIN;
            pressed_flag = 1'b0;
            rpt_count    = 0;
            pending_reports.delete();
        end else begin
            // results come out before the events that follow them, so compare first
            if (i_rpt.valid && i_rpt.ready) begin
                if (pending_reports.size() == 0) begin
                    flag_error($sformatf("unexpected report, kind %0d slot %0d",
                                         i_rpt.report_kind, i_rpt.slot_number));
                end else begin
                    want = pending_reports.pop_front();
                    if (i_rpt.report_kind !== want.rpt.kind)
                        flag_error($sformatf("kind got %0d expected %0d",
                                             i_rpt.report_kind, want.rpt.kind));
                    if (i_rpt.slot_number !== want.rpt.slot)
                        flag_error($sformatf("slot got %0d expected %0d",
                                             i_rpt.slot_number, want.rpt.slot));
                    if (i_rpt.touch_major !== want.rpt.major)
                        flag_error($sformatf("touch_major got %0d expected %0d",
                                             i_rpt.touch_major, want.rpt.major));
                    if (i_rpt.out_x !== want.rpt.x)
                        flag_error($sformatf("out_x got %0d expected %0d",
                                             i_rpt.out_x, want.rpt.x));
                    if (i_rpt.out_y !== want.rpt.y)
                        flag_error($sformatf("out_y got %0d expected %0d",
                                             i_rpt.out_y, want.rpt.y));
                    if (i_rpt.button_down !== want.rpt.btn)
                        flag_error($sformatf("button_down got %0b expected %0b",
                                             i_rpt.button_down, want.rpt.btn));
                    if (i_rpt.any_virtual_pressed !== want.pressed)
                        flag_error($sformatf("any_virtual_pressed got %0b expected %0b",
                                             i_rpt.any_virtual_pressed, want.pressed));
                    if (i_rpt.last !== want.last)
                        flag_error($sformatf("last got %0b expected %0b",
                                             i_rpt.last, want.last));
                end
                rpt_count++;
            end
            if (i_evt.valid && i_evt.ready)
                predict_reports(i_evt.finger_id, i_evt.press, i_evt.pos_x, i_evt.pos_y,
                                i_evt.exact_position, i_evt.real_finger_down);
        end
        o_pending <= pending_reports.size();
    end

endmodule

`default_nettype wire

>>> tb/sv/virtual_touch_slot_mapper_tb.sv
`timescale 1ns / 1ps
`default_nettype none

module virtual_touch_slot_mapper_tb;
    import vtsm_pkg::*;

    localparam int NUM_SLOTS = 16;
    // capture, one read per slot, last read data, commit
    localparam int EVENT_CYCLES = NUM_SLOTS + 3;

    localparam logic PRESS   = 1'b1;
    localparam logic RELEASE = 1'b0;

    localparam logic signed [14:0] POS_MIN = 15'h4000;
    localparam logic signed [14:0] POS_MAX = 15'h3FFF;

    localparam int POOL_SIZE    = 20;   // more ids than slots, so the table can fill
    localparam int BURST_LEN    = 37;
    localparam int BURSTS       = 10;   // per idle phase
    localparam int IDLE_PHASES  = 5;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // percent of cycles in which the sender holds off / the receiver stalls
    int sender_idle_pct = 0;
    int rcv_stall_pct   = 0;

    int fail_count;
    int pending;

    // ids used by the well-formed part of the random stimulus
    logic [7:0] finger_pool [POOL_SIZE];

    vtsm_in_if  evt_ch ();
    vtsm_out_if rpt_ch ();

    virtual_touch_slot_mapper #(
        .NUM_SLOTS(NUM_SLOTS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (evt_ch),
        .o_out   (rpt_ch)
    );

    vtsm_checker #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (evt_ch),
        .i_rpt        (rpt_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver side: ready is redrawn every cycle from the current stall rate
    initial begin
        rpt_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rpt_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // one finger event: random hold-off first, then hold valid until the transfer.
    // entered and left on a rising edge, so valid is assigned at most once per step
    task automatic send_event(
        input logic [7:0]         id,
        input logic               press,
        input logic signed [14:0] px,
        input logic signed [14:0] py,
        input logic               exact,
        input logic               real_down
    );
        while ($urandom_range(99) < sender_idle_pct) begin
            evt_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        evt_ch.valid            <= 1'b1;
        evt_ch.finger_id        <= id;
        evt_ch.press            <= press;
        evt_ch.pos_x            <= px;
        evt_ch.pos_y            <= py;
        evt_ch.exact_position   <= exact;
        evt_ch.real_finger_down <= real_down;
        do
            @(posedge i_clk);
        while (!evt_ch.ready);
    endtask

    // coordinates: mostly random, sometimes pinned to either end of the range
    function automatic logic signed [14:0] pick_pos();
        case ($urandom_range(7))
            0: return POS_MIN;
            1: return POS_MAX;
            default: return 15'($urandom);
        endcase
    endfunction

    // mostly press/move/release traffic over the id pool, with some noise ids
    // (anything up to 255) mixed in; the press bias decides whether slots fill or drain
    task automatic random_event(input int press_bias);
        logic [7:0] id;
        logic       press;

        if ($urandom_range(99) < 8) begin
            id    = 8'($urandom_range(255));
            press = 1'($urandom_range(1));
        end else begin
            id    = finger_pool[$urandom_range(POOL_SIZE - 1)];
            press = ($urandom_range(99) < press_bias);
        end
        send_event(id, press, pick_pos(), pick_pos(), 1'($urandom_range(1)),
                   ($urandom_range(99) < 40));
    endtask

    initial begin
        int press_bias;

        i_rst_n                 <= 1'b0;
        evt_ch.valid            <= 1'b0;
        evt_ch.finger_id        <= '0;
        evt_ch.press            <= 1'b0;
        evt_ch.pos_x            <= '0;
        evt_ch.pos_y            <= '0;
        evt_ch.exact_position   <= 1'b0;
        evt_ch.real_finger_down <= 1'b0;

        // extreme ids always in the pool, the rest drawn at random
        finger_pool[0] = 8'd0;
        finger_pool[1] = 8'd254;
        for (int i = 2; i < POOL_SIZE; i++)
            finger_pool[i] = 8'($urandom_range(1, 253));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, full speed
        // release of an id nobody holds on an empty table: button-up only
        send_event(8'd0,   RELEASE, 15'sd0,  15'sd0,  1'b0, 1'b0);
        // first press of the lowest id at the corner, jitter applied
        send_event(8'd0,   PRESS,   POS_MIN, POS_MAX, 1'b0, 1'b0);
        // move of the same id, exact position, real finger down: same slot
        send_event(8'd0,   PRESS,   POS_MAX, POS_MIN, 1'b1, 1'b1);
        // highest valid id takes the next empty slot
        send_event(8'd254, PRESS,   POS_MAX, POS_MAX, 1'b0, 1'b0);
        // id 255 never maps to a slot, in either direction
        send_event(8'd255, PRESS,   POS_MIN, POS_MIN, 1'b0, 1'b0);
        send_event(8'd255, RELEASE, POS_MIN, POS_MIN, 1'b1, 1'b0);
        send_event(8'd254, RELEASE, 15'sd0,  15'sd0,  1'b0, 1'b1);
        // fill every remaining slot
        for (int i = 1; i < NUM_SLOTS; i++)
            send_event(8'(i), PRESS, 15'(i * 1000), -15'(i * 1000), 1'(i % 2), 1'(i % 3 == 0));
        // table full, new id is dropped
        send_event(8'd200, PRESS,   15'sd7,  15'sd7,  1'b0, 1'b0);
        // release with the table still mostly held
        send_event(8'd0,   RELEASE, 15'sd0,  15'sd0,  1'b0, 1'b0);

        // random part, one idle pattern per phase
        for (int phase = 0; phase < IDLE_PHASES; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    rcv_stall_pct   = 0;
                end
                1: begin
                    sender_idle_pct = 85;
                    rcv_stall_pct   = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    rcv_stall_pct   = 85;
                end
                3: begin
                    sender_idle_pct = 23;
                    rcv_stall_pct   = 23;
                end
                default: begin
                    sender_idle_pct = 0;
                    rcv_stall_pct   = 0;
                end
            endcase
            for (int b = 0; b < BURSTS; b++) begin
                case ($urandom_range(2))
                    0: press_bias = 25;     // mostly releases, table drains
                    1: press_bias = 55;
                    default: press_bias = 85;   // mostly presses, table fills up
                endcase
                for (int n = 0; n < BURST_LEN; n++)
                    random_event(press_bias);
            end
        end

        // all events sent: stop driving and let the reports drain
        evt_ch.valid    <= 1'b0;
        sender_idle_pct = 0;
        rcv_stall_pct   = 0;
        do
            @(posedge i_clk);
        while (pending != 0);
        // catch any stray report still on its way
        repeat (4 * EVENT_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
src/vtsm_pkg.sv
src/vtsm_ifs.sv
src/virtual_touch_slot_mapper.sv
tb/sv/vtsm_checker.sv
tb/sv/virtual_touch_slot_mapper_tb.sv
